[rtl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the base64url stream decoder
// Holds the result codes, the result and result-list structs, the sizing of
// the output queue and the character-to-sextet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Result kinds carried on result_kind.
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_ERR = 2'd2;

	// The pad character '='.
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// Output queue sizing.
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// Most results a single character can cause: three bytes and an end result.
	localparam int MAX_RESULTS = 4;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] entry;
		logic [2:0]                count;
	} result_list_t;

	// Returns {bad, sextet}. Both the standard and URL-safe alphabets map.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		begin
			if (c >= "A" && c <= "Z") begin
				r = {1'b0, 6'(c - "A")};
			end else if (c >= "a" && c <= "z") begin
				r = {1'b0, 6'(c - "a" + 8'd26)};
			end else if (c >= "0" && c <= "9") begin
				r = {1'b0, 6'(c - "0" + 8'd52)};
			end else if (c == "+" || c == "-") begin
				r = {1'b0, 6'd62};
			end else if (c == "/" || c == "_") begin
				r = {1'b0, 6'd63};
			end else begin
				r = {1'b1, 6'd0};
			end
			return r;
		end
	endfunction

endpackage

[rtl/b64d_in_stage.sv]
// ----------------------------------------------------------------------------
// b64d_in_stage: input register of the decoder
// Captures one character beat and holds it until the decode stage passes it on.
// ----------------------------------------------------------------------------
module b64d_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       final_char,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] char_s1,
	output logic       final_s1
);

	logic accept;

	// The register frees up in the same cycle that its beat moves on.
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= char_code;
			final_s1 <= final_char;
		end
	end

endmodule

[rtl/b64d_decode.sv]
// ----------------------------------------------------------------------------
// b64d_decode: quartet state and result builder
// Maps the held character to a sextet, updates the quartet state, and builds
// the list of results (bytes and end result) that the character causes.
// ----------------------------------------------------------------------------
module b64d_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [7:0]            char_s1,
	input  logic                  final_s1,
	input  logic                  advance,
	output b64d_pkg::result_list_t list
);

	import b64d_pkg::*;

	logic [17:0] held_q;
	logic [1:0]  slot_q;
	logic        tpad_q;
	logic        err_q;

	logic [6:0]  sx;
	logic [5:0]  v;
	logic        is_pad;
	logic        bad;
	logic        err1;
	logic        err_end;
	logic [23:0] quartet;
	logic        pad3;
	logic        pad4;
	logic        emit;
	logic        bytes_ok;
	logic [2:0]  n;
	logic [2:0]  n_m1;

	assign sx     = sextet_of(char_s1);
	assign is_pad = (char_s1 == CHAR_PAD);
	// A pad is legal only in the third or fourth slot.
	assign bad    = sx[6] && !(slot_q[1] && is_pad);
	assign v      = sx[6] ? 6'd0 : sx[5:0];
	assign err1   = err_q || bad;
	// A lone character at the end is padded in slot two, which is an error.
	assign err_end = err1 || (final_s1 && slot_q == 2'd0);

	// Assemble the quartet that completes now, padding it when the string ends.
	always_comb begin
		unique case (slot_q)
			2'd3: begin
				quartet = {held_q, v};
				pad3    = tpad_q;
				pad4    = is_pad;
				emit    = 1'b1;
			end
			2'd2: begin
				quartet = {held_q[11:0], v, 6'd0};
				pad3    = is_pad;
				pad4    = 1'b1;
				emit    = final_s1;
			end
			2'd1: begin
				quartet = {held_q[5:0], v, 12'd0};
				pad3    = 1'b1;
				pad4    = 1'b1;
				emit    = final_s1;
			end
			default: begin
				quartet = {v, 18'd0};
				pad3    = 1'b1;
				pad4    = 1'b1;
				emit    = 1'b0;
			end
		endcase
	end

	assign bytes_ok = emit && !err_end;

	// Pack the results in order and mark the last one.
	always_comb begin
		list = '0;
		n    = 3'd0;
		if (bytes_ok) begin
			list.entry[n[1:0]] = '{data: quartet[23:16], kind: KIND_BYTE, last: 1'b0};
			n = n + 3'd1;
			if (!pad3) begin
				list.entry[n[1:0]] = '{data: quartet[15:8], kind: KIND_BYTE, last: 1'b0};
				n = n + 3'd1;
			end
			if (!pad4) begin
				list.entry[n[1:0]] = '{data: quartet[7:0], kind: KIND_BYTE, last: 1'b0};
				n = n + 3'd1;
			end
		end
		if (final_s1) begin
			list.entry[n[1:0]] = '{data: 8'd0,
				kind: (err_end ? KIND_END_ERR : KIND_END_OK), last: 1'b0};
			n = n + 3'd1;
		end
		n_m1 = n - 3'd1;
		if (n != 3'd0) begin
			list.entry[n_m1[1:0]].last = 1'b1;
		end
		list.count = valid_s1 ? n : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			slot_q <= '0;
			tpad_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (advance) begin
			if (final_s1) begin
				held_q <= '0;
				slot_q <= '0;
				tpad_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				slot_q <= slot_q + 2'd1;
				err_q  <= err1;
				if (slot_q == 2'd3) begin
					held_q <= '0;
					tpad_q <= 1'b0;
				end else begin
					held_q <= {held_q[11:0], v};
					if (slot_q == 2'd2) begin
						tpad_q <= is_pad;
					end
				end
			end
		end
	end

	// Only the character that fills the fourth slot, or the final one, has results.
	a_quiet_mid_quartet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !final_s1 && slot_q != 2'd3) |-> list.count == 3'd0)
		else $error("result produced before a quartet completed");

	// The end of a string leaves a clean state for the next one.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_s1) |=> (slot_q == 2'd0 && !err_q && !tpad_q))
		else $error("state not cleared after end of string");

	// A final character always closes its list with an end result.
	a_final_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_s1) |-> list.count != 3'd0)
		else $error("final character produced no end result");

endmodule

[rtl/b64d_out_queue.sv]
// ----------------------------------------------------------------------------
// b64d_out_queue: result queue of the decoder
// Takes a whole result list at once, hands out one beat per cycle on out_ready.
// ----------------------------------------------------------------------------
module b64d_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64d_pkg::result_list_t list,
	input  logic                  load,
	output logic                  can_load,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic [1:0]            result_kind,
	output logic                  run_last
);

	import b64d_pkg::*;

	result_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  free_slots;
	logic               pop;
	result_t            head;

	assign free_slots = FILL_W'(QUEUE_DEPTH) - fill_q;
	assign can_load   = FILL_W'(list.count) <= free_slots;

	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	assign out_byte    = head.data;
	assign result_kind = head.kind;
	assign run_last    = head.last;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				if (3'(i) < list.count) begin
					mem_q[wr_ptr_q + QPTR_W'(i)] <= list.entry[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (load) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(list.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			fill_q <= fill_q + (load ? FILL_W'(list.count) : '0) - (pop ? FILL_W'(1) : '0);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// Taking a beat that is not the last one leaves another behind it.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !run_last) |=> out_valid)
		else $error("result run broken off before its last beat");

endmodule

[rtl/base64url_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top: base64 / base64url stream decoder
// Decodes one character per cycle, queue permitting, into bytes and end results.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one character per beat in
// char_code, with final_char set on the last character of a string. Both the
// standard and the URL-safe alphabets are accepted. The output channel
// (out_valid/out_ready) carries result beats: decoded bytes (result_kind 0),
// then one end result per string (1 for success, 2 for error). run_last is set
// on the last beat caused by a character; characters that neither complete a
// quartet nor end a string cause no beat at all.
// An accepted character waits in the input register until its results fit in
// the result queue. Throughput: one character per cycle, held by the output
// port, which moves one result beat per cycle while out_ready is high. An
// eight-entry result queue absorbs the burst of up to four beats from one
// character, so a string streams at full rate while the receiver takes beats
// without stalls. When the receiver stalls, the queue fills and in_ready drops
// once the next character's results no longer fit; nothing is lost or dropped.
// Reset (arst_n low) empties the queue and clears the quartet and error state.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] result_kind,
	output logic       run_last
);

	import b64d_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         final_s1;
	logic         can_load;
	logic         advance;
	result_list_t list;

	// The held character moves on, and the quartet state updates, as soon as
	// the queue has room for every result that character causes.
	assign advance = valid_s1 && can_load;

	b64d_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.final_char (final_char),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.char_s1    (char_s1),
		.final_s1   (final_s1)
	);

	b64d_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.final_s1 (final_s1),
		.advance  (advance),
		.list     (list)
	);

	b64d_out_queue u_out_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.list        (list),
		.load        (advance),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.result_kind (result_kind),
		.run_last    (run_last)
	);

endmodule
